>>> sv/wmb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wmb_pkg: shared definitions for the wind moving mean core
// Widths, the job record passed from front to back, and the Beaufort tables.
// ----------------------------------------------------------------------------
package wmb_pkg;

  localparam int WINDOW     = 64;
  localparam int SAMPLE_W   = 21;
  localparam int PTR_W      = $clog2(WINDOW);
  localparam int CNT_W      = $clog2(WINDOW + 1);
  localparam int SUM_W      = SAMPLE_W + CNT_W;
  localparam int STEP_W     = $clog2(SUM_W);
  localparam int BFT_W      = 4;
  localparam int WAVE_W     = 14;
  localparam int NUM_LIMITS = 11;
  localparam int JOBQ_DEPTH = 2;
  localparam int JOBQ_PTR_W = $clog2(JOBQ_DEPTH);

  localparam int BFT_LIMIT [0:NUM_LIMITS-1] = '{
    999, 5000, 11000, 19000, 28000, 38000, 49000, 61000, 74000, 88000, 102000
  };

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
    logic             upd;
  } job_t;

  function automatic logic [BFT_W-1:0] bft_code(input logic signed [SAMPLE_W-1:0] m);
    logic [BFT_W-1:0] code;
    code = BFT_W'(NUM_LIMITS);
    for (int i = NUM_LIMITS - 1; i >= 0; i--) begin
      if (int'(m) <= BFT_LIMIT[i]) begin
        code = BFT_W'(i);
      end
    end
    return code;
  endfunction

  function automatic logic [WAVE_W-1:0] wave_of(input logic [BFT_W-1:0] code);
    logic [WAVE_W-1:0] w;
    case (code)
      4'd0:    w = 14'd0;
      4'd1:    w = 14'd10;
      4'd2:    w = 14'd50;
      4'd3:    w = 14'd125;
      4'd4:    w = 14'd250;
      4'd5:    w = 14'd400;
      4'd6:    w = 14'd600;
      4'd7:    w = 14'd600;
      4'd8:    w = 14'd900;
      4'd9:    w = 14'd900;
      4'd10:   w = 14'd1400;
      4'd11:   w = 14'd10000;
      default: w = 14'd0;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

>>> sv/wmb_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wmb_front: sample ring and running sum
// Stores each sample, keeps the running sum and count, decides whether the
// mean is due, and hands a job to the back end.
// ----------------------------------------------------------------------------
module wmb_front (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire logic signed [wmb_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic                        in_hour_elapsed,
  input  wire logic                        in_push,
  output logic                             in_full,
  output wmb_pkg::job_t                    job,
  output logic                             job_push,
  input  wire logic                        job_full
);
  import wmb_pkg::*;

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_RMV  = 2'b10
  } fstate_t;

  fstate_t                    state_r, state_nxt;
  logic [PTR_W-1:0]           head_r;
  logic [CNT_W-1:0]           count_r;
  logic [SUM_W-1:0]           sum_r;
  logic [SAMPLE_W-1:0]        sample_r;
  logic [SAMPLE_W-1:0]        rd_r;
  logic                       byp_r;
  logic [SAMPLE_W-1:0]        ring [0:WINDOW-1];

  logic                       accept;
  logic [CNT_W-1:0]           cnt_add;
  logic [SUM_W-1:0]           sum_add;
  logic                       upd;
  logic [PTR_W:0]             wa_full;
  logic [PTR_W-1:0]           wa;
  logic [PTR_W-1:0]           head_inc;
  logic [SAMPLE_W-1:0]        rm_val;

  assign in_full  = (state_r != F_IDLE) || job_full;
  assign accept   = in_push && !in_full;
  assign cnt_add  = count_r + 1'b1;
  assign sum_add  = sum_r + {{(SUM_W-SAMPLE_W){in_sample[SAMPLE_W-1]}}, in_sample};
  assign upd      = in_hour_elapsed || (cnt_add == CNT_W'(WINDOW));
  assign wa_full  = {1'b0, head_r} + {1'b0, count_r[PTR_W-1:0]};
  assign wa       = (wa_full >= (PTR_W+1)'(WINDOW)) ?
                    PTR_W'(wa_full - (PTR_W+1)'(WINDOW)) : wa_full[PTR_W-1:0];
  assign head_inc = (head_r == PTR_W'(WINDOW - 1)) ? '0 : head_r + 1'b1;
  assign rm_val   = byp_r ? sample_r : rd_r;

  assign job_push = accept;
  assign job      = '{sum: sum_add, cnt: cnt_add, upd: upd};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept && upd) begin
          state_nxt = F_RMV;
        end
      end
      F_RMV: begin
        state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      head_r  <= '0;
      count_r <= '0;
      sum_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        sum_r <= sum_add;
        if (upd) begin
          count_r <= count_r;
          head_r  <= head_inc;
        end else begin
          count_r <= cnt_add;
        end
      end else if (state_r == F_RMV) begin
        sum_r <= sum_r - {{(SUM_W-SAMPLE_W){rm_val[SAMPLE_W-1]}}, rm_val};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ring[wa] <= in_sample;
      rd_r     <= ring[head_r];
      sample_r <= in_sample;
      byp_r    <= (count_r == '0);
    end
  end

  a_count_below_window: assert property (@(posedge clk) disable iff (!rst_n)
    count_r < CNT_W'(WINDOW))
    else $error("Ring count reached the window size.");

  a_head_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, head_r} < (PTR_W+1)'(WINDOW))
    else $error("Ring head out of range.");

  a_rmv_after_update: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == F_RMV) |-> $past(accept && upd))
    else $error("Oldest-sample removal without an updating transaction.");

endmodule
`default_nettype wire

>>> sv/wmb_jobq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wmb_jobq: job queue between front and back
// A two-entry first-in first-out queue of jobs.
// ----------------------------------------------------------------------------
module wmb_jobq (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire logic           push,
  input  wire wmb_pkg::job_t  push_data,
  output logic                full,
  input  wire logic           pop,
  output wmb_pkg::job_t       pop_data,
  output logic                empty
);
  import wmb_pkg::*;

  job_t                 mem [0:JOBQ_DEPTH-1];
  logic [JOBQ_PTR_W-1:0] wptr_r, rptr_r;
  logic [JOBQ_PTR_W:0]   fill_r;
  logic                  do_push, do_pop;

  assign full     = (fill_r == (JOBQ_PTR_W+1)'(JOBQ_DEPTH));
  assign empty    = (fill_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fill_r <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr_r] <= push_data;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("Job pushed into a full queue.");

endmodule
`default_nettype wire

>>> sv/wmb_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wmb_back: mean divider and Beaufort classifier
// Divides the running sum by the count one quotient bit per cycle, holds the
// current mean, classifies it and presents the result register.
// ----------------------------------------------------------------------------
module wmb_back (
  input  wire                                      clk,
  input  wire                                      rst_n,
  input  wire wmb_pkg::job_t                       job,
  input  wire logic                                job_empty,
  output logic                                     job_pop,
  output logic signed [wmb_pkg::SAMPLE_W-1:0]      out_mean_velocity,
  output logic                                     out_mean_updated,
  output logic                                     out_fault,
  output logic [wmb_pkg::BFT_W-1:0]                out_beaufort,
  output logic [wmb_pkg::WAVE_W-1:0]               out_wave_height_cm,
  output logic                                     out_empty,
  input  wire logic                                out_pop
);
  import wmb_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_DIV  = 4'b0010,
    B_FIN  = 4'b0100,
    B_CLS  = 4'b1000
  } bstate_t;

  bstate_t                     state_r, state_nxt;
  logic [CNT_W-1:0]            rem_r;
  logic [SUM_W-1:0]            quo_r;
  logic [CNT_W-1:0]            div_r;
  logic                        neg_r;
  logic                        upd_r;
  logic [STEP_W-1:0]           step_r;
  logic signed [SAMPLE_W-1:0]  mean_r;
  logic                        out_valid_r;

  logic [CNT_W:0]              rem_sh;
  logic                        ge;
  logic [CNT_W:0]              rem_sub;
  logic                        job_neg;
  logic [SUM_W-1:0]            job_abs;
  logic                        fault;
  logic [BFT_W-1:0]            code;
  logic                        out_write;

  assign job_neg   = job.sum[SUM_W-1];
  assign job_abs   = job_neg ? (~job.sum + 1'b1) : job.sum;
  assign rem_sh    = {rem_r, quo_r[SUM_W-1]};
  assign ge        = rem_sh >= {1'b0, div_r};
  assign rem_sub   = rem_sh - {1'b0, div_r};
  assign fault     = mean_r[SAMPLE_W-1] || (mean_r == '0);
  assign code      = fault ? '0 : bft_code(mean_r);
  assign job_pop   = (state_r == B_IDLE) && !job_empty;
  assign out_write = (state_r == B_CLS) && !out_valid_r;
  assign out_empty = !out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (!job_empty) begin
          state_nxt = job.upd ? B_DIV : B_CLS;
        end
      end
      B_DIV: begin
        if (step_r == STEP_W'(SUM_W - 1)) begin
          state_nxt = B_FIN;
        end
      end
      B_FIN: begin
        state_nxt = B_CLS;
      end
      B_CLS: begin
        if (!out_valid_r) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      mean_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_FIN) begin
        mean_r <= neg_r ? -quo_r[SAMPLE_W-1:0] : quo_r[SAMPLE_W-1:0];
      end
      if (out_write) begin
        out_valid_r <= 1'b1;
      end else if (out_pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      upd_r  <= job.upd;
      div_r  <= job.cnt;
      neg_r  <= job_neg;
      quo_r  <= job_abs;
      rem_r  <= '0;
      step_r <= '0;
    end else if (state_r == B_DIV) begin
      rem_r  <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      quo_r  <= {quo_r[SUM_W-2:0], ge};
      step_r <= step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_write) begin
      out_mean_velocity  <= mean_r;
      out_mean_updated   <= upd_r;
      out_fault          <= fault;
      out_beaufort       <= code;
      out_wave_height_cm <= wave_of(code);
    end
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV) |-> (div_r != '0))
    else $error("Mean division by a zero count.");

  a_fault_clears_class: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fault) |-> (out_beaufort == '0 && out_wave_height_cm == '0))
    else $error("Fault result carries a Beaufort class.");

endmodule
`default_nettype wire

>>> sv/wind_moving_mean_beaufort_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wind_moving_mean_beaufort_core: moving mean wind speed with Beaufort class
// Ring of 64 samples, running sum, iterative mean divider and classifier.
// ----------------------------------------------------------------------------
// Each sample pushed gives exactly one result. The front end takes a sample
// and, when the mean is updated, passes through its removal state to take
// the oldest sample out of the sum. A two-entry job queue decouples it from
// the back end. For a sample that updates the mean, the back end loads the
// job, divides one quotient bit per cycle of the 28-bit running sum, fixes
// the sign and classifies; for one that does not, it classifies the current
// mean straight after the load. The divider bounds the sustained rate. The
// result register holds one finished transaction while later samples are
// already being taken. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module wind_moving_mean_beaufort_core (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire logic signed [wmb_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic                            in_hour_elapsed,
  input  wire logic                            in_push,
  output logic                                 in_full,
  output logic signed [wmb_pkg::SAMPLE_W-1:0]  out_mean_velocity,
  output logic                                 out_mean_updated,
  output logic                                 out_fault,
  output logic [wmb_pkg::BFT_W-1:0]            out_beaufort,
  output logic [wmb_pkg::WAVE_W-1:0]           out_wave_height_cm,
  output logic                                 out_empty,
  input  wire logic                            out_pop
);
  import wmb_pkg::*;

  job_t front_job;
  job_t back_job;
  logic job_push;
  logic job_full;
  logic job_pop;
  logic job_empty;

  wmb_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_sample       (in_sample),
    .in_hour_elapsed (in_hour_elapsed),
    .in_push         (in_push),
    .in_full         (in_full),
    .job             (front_job),
    .job_push        (job_push),
    .job_full        (job_full)
  );

  wmb_jobq u_jobq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (front_job),
    .full      (job_full),
    .pop       (job_pop),
    .pop_data  (back_job),
    .empty     (job_empty)
  );

  wmb_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .job                (back_job),
    .job_empty          (job_empty),
    .job_pop            (job_pop),
    .out_mean_velocity  (out_mean_velocity),
    .out_mean_updated   (out_mean_updated),
    .out_fault          (out_fault),
    .out_beaufort       (out_beaufort),
    .out_wave_height_cm (out_wave_height_cm),
    .out_empty          (out_empty),
    .out_pop            (out_pop)
  );

endmodule
`default_nettype wire
